// ----- sv/assert_macros.svh -----
// Assertion helper macros shared by the RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- sv/irdlf_pkg.sv -----
// Package for the IR distance conditioner: constants, state enum, command and status structs.
// No dependencies.
package irdlf_pkg;
	localparam int TABLE_POINTS = 64;
	localparam int ADC_BITS     = 10;
	localparam int IDX_W        = 6;
	localparam int ADDR_W       = 7;
	localparam int RAW_W        = 18;
	localparam int NUM_W        = 28;
	localparam int DEN_W        = 11;

	localparam logic [2:0] REG_SNAP   = 3'd0;
	localparam logic [2:0] REG_MEDT   = 3'd1;
	localparam logic [2:0] REG_MEDG   = 3'd2;
	localparam logic [2:0] REG_SLOWG  = 3'd3;
	localparam logic [2:0] REG_MIND   = 3'd4;
	localparam logic [2:0] REG_MAXD   = 3'd5;
	localparam logic [2:0] REG_LEFTN  = 3'd6;
	localparam logic [2:0] REG_FRONTN = 3'd7;

	localparam logic [1:0] MODE_FIRST  = 2'd0;
	localparam logic [1:0] MODE_SNAP   = 2'd1;
	localparam logic [1:0] MODE_MEDIUM = 2'd2;
	localparam logic [1:0] MODE_SLOW   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD0, ST_CHK0, ST_CHKN, ST_SCAN, ST_SCANW,
		ST_SEG, ST_SEGW, ST_MUL, ST_DIV, ST_FIX, ST_FILT, ST_BLEND, ST_OUT
	} state_t;

	typedef struct packed {
		logic                  load_item;
		logic                  write_point;
		logic                  rd_first;
		logic                  rd_last;
		logic                  rd_scan;
		logic                  rd_seg;
		logic                  latch_a;
		logic                  latch_b;
		logic                  latch_seg;
		logic                  mul_go;
		logic                  div_start;
		logic                  div_step;
		logic                  fix_raw;
		logic                  filt;
		logic                  blend;
		logic                  out_load;
		logic [IDX_W-1:0]      seg_idx;
	} cmd_t;

	typedef struct packed {
		logic              op;
		logic              code_ge_first;
		logic              code_le_last;
		logic              bracket;
		logic              last_pair;
		logic              div_done;
		logic              div_skip;
		logic              need_blend;
		logic [IDX_W-1:0]  last_idx;
		logic [IDX_W-1:0]  scan_i;
	} sts_t;
endpackage

// ----- sv/ir_distance_linearize_filter_core.sv -----
// Top level of the IR distance conditioner.
// Depends on irdlf_pkg, irdlf_ctrl, irdlf_dp and assert_macros.svh.
//
// Input channel (in_valid/in_ready) takes one beat per item: op 0 writes a
// calibration point of a channel, op 1 is a sample. A sample gives one
// result beat on the output channel (out_valid/out_ready); a point write
// gives none. Items are handled one at a time. A sample scans up to 63
// table pairs through the point memory's read ports, then runs the
// restoring bit-serial divider, which is cut short when the segment's
// codes are equal. The configuration port writes a register whenever
// cfg_we is high. Reset restores register defaults, clears both filters
// and marks both channels as waiting for their first sample; calibration
// memory content is undefined until written. When the receiver stalls,
// the finished result holds in the output register and the block takes
// point writes and one more sample, then waits in its last step.
`include "assert_macros.svh"
module ir_distance_linearize_filter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic               channel,
	input  logic [5:0]         point_index,
	input  logic [7:0]         point_distance,
	input  logic [9:0]         point_code,
	input  logic [9:0]         sample_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_channel,
	output logic [15:0]        distance,
	output logic signed [17:0] raw_distance,
	output logic [1:0]         filter_mode,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	irdlf_pkg::cmd_t cmd;
	irdlf_pkg::sts_t sts;

	logic [15:0] snap_q, medt_q, mind_q, maxd_q;
	logic [8:0]  medg_q, slowg_q;
	logic [6:0]  leftn_q, frontn_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q <= 16'd3840; medt_q <= 16'd1280; medg_q <= 9'd128;
			slowg_q <= 9'd38; mind_q <= 16'd1792; maxd_q <= 16'd16640;
			leftn_q <= 7'd36; frontn_q <= 7'd36;
		end else if (cfg_we) begin
			unique case (cfg_index)
				irdlf_pkg::REG_SNAP:   snap_q   <= cfg_data;
				irdlf_pkg::REG_MEDT:   medt_q   <= cfg_data;
				irdlf_pkg::REG_MEDG:   medg_q   <= cfg_data[8:0];
				irdlf_pkg::REG_SLOWG:  slowg_q  <= cfg_data[8:0];
				irdlf_pkg::REG_MIND:   mind_q   <= cfg_data;
				irdlf_pkg::REG_MAXD:   maxd_q   <= cfg_data;
				irdlf_pkg::REG_LEFTN:  leftn_q  <= cfg_data[6:0];
				irdlf_pkg::REG_FRONTN: frontn_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	irdlf_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	irdlf_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .op, .channel, .point_index, .point_distance,
		.point_code, .sample_code, .snap_q, .medt_q, .medg_q, .slowg_q, .mind_q,
		.maxd_q, .leftn_q, .frontn_q, .result_channel, .distance, .raw_distance,
		.filter_mode
	);

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped")
	`ASSERT_CLK(a_load_ready, clk, arst_n, cmd.load_item |-> in_ready, "item taken while busy")
	`ASSERT_ALWAYS(a_one_cmd, clk, arst_n, $onehot0({cmd.filt, cmd.blend, cmd.out_load}), "overlap")
endmodule

// ----- sv/irdlf_ctrl.sv -----
// Sequencer of the IR distance conditioner: one item at a time.
// Depends on irdlf_pkg.
module irdlf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  irdlf_pkg::sts_t   sts,
	output irdlf_pkg::cmd_t   cmd
);
	irdlf_pkg::state_t state_q, state_nx;
	logic [irdlf_pkg::IDX_W-1:0] idx_q, idx_nx;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= irdlf_pkg::ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			idx_q   <= idx_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	// Next item may enter while a result waits, but a new result cannot overwrite it.
	assign in_ready  = (state_q == irdlf_pkg::ST_IDLE);

	always_comb begin
		state_nx = state_q;
		idx_nx   = idx_q;
		unique case (state_q)
			irdlf_pkg::ST_IDLE: if (in_valid) state_nx = irdlf_pkg::ST_RD0;
			irdlf_pkg::ST_RD0: begin
				if (!sts.op) state_nx = irdlf_pkg::ST_IDLE;
				else state_nx = irdlf_pkg::ST_CHK0;
			end
			irdlf_pkg::ST_CHK0: begin
				if (sts.code_ge_first) begin
					idx_nx = '0;
					state_nx = irdlf_pkg::ST_SEG;
				end else state_nx = irdlf_pkg::ST_CHKN;
			end
			irdlf_pkg::ST_CHKN: begin
				if (sts.code_le_last) begin
					idx_nx = sts.last_idx - 1'b1;
					state_nx = irdlf_pkg::ST_SEG;
				end else begin
					idx_nx = '0;
					state_nx = irdlf_pkg::ST_SCAN;
				end
			end
			irdlf_pkg::ST_SCAN: state_nx = irdlf_pkg::ST_SCANW;
			irdlf_pkg::ST_SCANW: begin
				if (sts.bracket) state_nx = irdlf_pkg::ST_SEG;
				else if (sts.last_pair) state_nx = irdlf_pkg::ST_SEG;
				else begin
					idx_nx = idx_q + 1'b1;
					state_nx = irdlf_pkg::ST_SCAN;
				end
			end
			irdlf_pkg::ST_SEG: state_nx = irdlf_pkg::ST_SEGW;
			irdlf_pkg::ST_SEGW: state_nx = irdlf_pkg::ST_MUL;
			irdlf_pkg::ST_MUL: state_nx = irdlf_pkg::ST_DIV;
			irdlf_pkg::ST_DIV: if (sts.div_done || sts.div_skip) state_nx = irdlf_pkg::ST_FIX;
			irdlf_pkg::ST_FIX: state_nx = irdlf_pkg::ST_FILT;
			irdlf_pkg::ST_FILT: begin
				if (sts.need_blend) state_nx = irdlf_pkg::ST_BLEND;
				else state_nx = irdlf_pkg::ST_OUT;
			end
			irdlf_pkg::ST_BLEND: state_nx = irdlf_pkg::ST_OUT;
			irdlf_pkg::ST_OUT: if (!out_valid_q || out_ready) state_nx = irdlf_pkg::ST_IDLE;
			default: state_nx = irdlf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.seg_idx = idx_q;
		unique case (state_q)
			irdlf_pkg::ST_IDLE: cmd.load_item = in_valid;
			irdlf_pkg::ST_RD0: begin
				cmd.write_point = !sts.op;
				cmd.rd_first = sts.op;
			end
			irdlf_pkg::ST_CHK0: cmd.rd_last = 1'b1;
			irdlf_pkg::ST_CHKN: ;
			irdlf_pkg::ST_SCAN: cmd.rd_scan = 1'b1;
			irdlf_pkg::ST_SCANW: ;
			irdlf_pkg::ST_SEG: cmd.rd_seg = 1'b1;
			irdlf_pkg::ST_SEGW: cmd.latch_seg = 1'b1;
			irdlf_pkg::ST_MUL: cmd.mul_go = 1'b1;
			irdlf_pkg::ST_DIV: begin
				cmd.div_start = 1'b0;
				cmd.div_step = 1'b1;
			end
			irdlf_pkg::ST_FIX: cmd.fix_raw = 1'b1;
			irdlf_pkg::ST_FILT: cmd.filt = 1'b1;
			irdlf_pkg::ST_BLEND: cmd.blend = 1'b1;
			irdlf_pkg::ST_OUT: cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
		cmd.latch_a = 1'b0;
		cmd.latch_b = 1'b0;
	end
endmodule

// ----- sv/irdlf_dp.sv -----
// Datapath of the IR distance conditioner: calibration memories, divider, filter.
// Depends on irdlf_pkg.
module irdlf_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  irdlf_pkg::cmd_t     cmd,
	output irdlf_pkg::sts_t     sts,
	input  logic                op,
	input  logic                channel,
	input  logic [5:0]          point_index,
	input  logic [7:0]          point_distance,
	input  logic [9:0]          point_code,
	input  logic [9:0]          sample_code,
	input  logic [15:0]         snap_q,
	input  logic [15:0]         medt_q,
	input  logic [8:0]          medg_q,
	input  logic [8:0]          slowg_q,
	input  logic [15:0]         mind_q,
	input  logic [15:0]         maxd_q,
	input  logic [6:0]          leftn_q,
	input  logic [6:0]          frontn_q,
	output logic                result_channel,
	output logic [15:0]         distance,
	output logic signed [17:0]  raw_distance,
	output logic [1:0]          filter_mode
);
	// Memory of 128 (code,distance) pairs; two read ports.
	logic [17:0] mem [0:127];
	logic [17:0] rda_q, rdb_q;
	logic [6:0]  addra, addrb;

	logic        op_q, ch_q;
	logic [5:0]  pidx_q;
	logic [7:0]  pd_q;
	logic [9:0]  pc_q, code_q;
	logic [5:0]  last_idx;
	logic [6:0]  n_sat;

	always_comb begin
		n_sat = ch_q ? frontn_q : leftn_q;
		if (n_sat < 7'd2) n_sat = 7'd2;
		if (n_sat > 7'd64) n_sat = 7'd64;
		last_idx = 6'(n_sat - 7'd1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q <= op; ch_q <= channel; pidx_q <= point_index;
			pd_q <= point_distance; pc_q <= point_code; code_q <= sample_code;
		end
	end

	always_comb begin
		addra = {ch_q, cmd.seg_idx};
		addrb = {ch_q, 6'(cmd.seg_idx + 6'd1)};
		if (cmd.rd_first) begin addra = {ch_q, 6'd0}; addrb = {ch_q, 6'd0}; end
		if (cmd.rd_last) begin addra = {ch_q, last_idx}; addrb = {ch_q, last_idx}; end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_point) mem[{ch_q, pidx_q}] <= {pc_q, pd_q};
		rda_q <= mem[addra];
		rdb_q <= mem[addrb];
	end

	logic [9:0] ca, cb;
	assign ca = rda_q[17:8];
	assign cb = rdb_q[17:8];

	// Segment data and signed numerator/denominator.
	logic [9:0]  a0_q, a1_q;
	logic [7:0]  d0_q, d1_q;
	logic signed [27:0] num_s2;
	logic signed [11:0] den_s2;
	logic        neg_q, eq_q;
	logic [26:0] nmag_q, rem_q;
	logic [10:0] dmag_q;
	logic [4:0]  cnt_q;
	logic [26:0] quo_q;
	logic signed [17:0] raw_q;
	logic signed [17:0] filt_q [0:1];
	logic [1:0]  first_q;
	logic signed [17:0] f_s1;
	logic [8:0]  g_s1;
	logic [1:0]  mode_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_seg) begin
			a0_q <= ca; a1_q <= cb; d0_q <= rda_q[7:0]; d1_q <= rdb_q[7:0];
		end
		if (cmd.mul_go) begin
			num_s2 <= 28'(($signed({1'b0, code_q}) - $signed({1'b0, a0_q}))
				* ($signed({1'b0, d1_q}) - $signed({1'b0, d0_q}))) <<< 8;
			den_s2 <= $signed({2'b0, a1_q}) - $signed({2'b0, a0_q});
		end
	end

	logic signed [27:0] num_w;
	logic signed [11:0] den_w;
	assign num_w = num_s2;
	assign den_w = den_s2;

	// Restoring divider on magnitudes, one quotient bit a cycle.
	logic        started_q;
	logic [27:0] trial;
	always_comb trial = {rem_q, quo_q[26]} - {17'd0, dmag_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) started_q <= 1'b0;
		else if (cmd.div_step && !started_q) started_q <= 1'b1;
		else if (!cmd.div_step) started_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.div_step && !started_q) begin
			neg_q  <= num_w[27] ^ den_w[11];
			eq_q   <= (den_w == 12'sd0);
			quo_q  <= 27'(num_w[27] ? -num_w : num_w);
			dmag_q <= 11'(den_w[11] ? -den_w : den_w);
			rem_q  <= '0;
			cnt_q  <= 5'd27;
		end else if (cmd.div_step && cnt_q != 5'd0) begin
			if (!trial[27]) begin
				rem_q <= trial[26:0];
				quo_q <= {quo_q[25:0], 1'b1};
			end else begin
				rem_q <= {rem_q[25:0], quo_q[26]};
				quo_q <= {quo_q[25:0], 1'b0};
			end
			cnt_q <= cnt_q - 5'd1;
		end
	end
	assign sts.div_done = started_q && (cnt_q == 5'd0);
	assign sts.div_skip = started_q && eq_q;

	logic signed [29:0] rsum;
	always_comb begin
		rsum = $signed({22'd0, d0_q}) <<< 8;
		if (!eq_q) rsum = rsum + (neg_q ? -$signed({3'd0, quo_q}) : $signed({3'd0, quo_q}));
	end

	// Filter.
	logic signed [18:0] err;
	logic [18:0] eabs;
	logic signed [17:0] fcur;
	assign fcur = filt_q[ch_q];
	assign err  = 19'(raw_q) - 19'(fcur);
	assign eabs = err[18] ? 19'(-err) : err;

	logic [8:0] gm, gs;
	assign gm = (medg_q > 9'd256) ? 9'd256 : medg_q;
	assign gs = (slowg_q > 9'd256) ? 9'd256 : slowg_q;

	logic signed [28:0] bsum;
	assign bsum = 29'(f_s1) * $signed({20'd0, 9'(9'd256 - g_s1)})
		+ 29'(raw_q) * $signed({20'd0, g_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= 2'b11;
			filt_q[0] <= '0;
			filt_q[1] <= '0;
		end else begin
			if (cmd.filt) begin
				if (first_q[ch_q]) begin
					filt_q[ch_q] <= raw_q; first_q[ch_q] <= 1'b0;
				end else if (eabs > {3'd0, snap_q}) filt_q[ch_q] <= raw_q;
			end
			if (cmd.blend) filt_q[ch_q] <= 18'(bsum >>> 8);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fix_raw) begin
			if (rsum > 30'sd131071) raw_q <= 18'sd131071;
			else if (rsum < -30'sd131072) raw_q <= -18'sd131072;
			else raw_q <= 18'(rsum);
		end
		if (cmd.filt) begin
			f_s1 <= fcur;
			if (first_q[ch_q]) mode_q <= irdlf_pkg::MODE_FIRST;
			else if (eabs > {3'd0, snap_q}) mode_q <= irdlf_pkg::MODE_SNAP;
			else if (eabs > {3'd0, medt_q}) begin
				mode_q <= irdlf_pkg::MODE_MEDIUM; g_s1 <= gm;
			end else begin
				mode_q <= irdlf_pkg::MODE_SLOW; g_s1 <= gs;
			end
		end
	end

	assign sts.need_blend = !first_q[ch_q] && !(eabs > {3'd0, snap_q});

	logic [15:0] dclamp;
	always_comb begin
		if ($signed({fcur[17], fcur}) <= $signed({3'd0, mind_q})) dclamp = mind_q;
		else if ($signed({fcur[17], fcur}) >= $signed({3'd0, maxd_q})) dclamp = maxd_q;
		else dclamp = 16'(fcur);
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_channel <= ch_q;
			distance       <= dclamp;
			raw_distance   <= raw_q;
			filter_mode    <= mode_q;
		end
	end

	// Scan compare on registered pair.
	logic [5:0] scan_i;
	assign scan_i = cmd.seg_idx;
	assign sts.op = op_q;
	assign sts.code_ge_first = code_q >= ca;
	assign sts.code_le_last  = code_q <= ca;
	assign sts.bracket = (ca >= cb) ? (code_q <= ca && code_q >= cb)
		: (code_q >= ca && code_q <= cb);
	assign sts.last_pair = (scan_i == 6'(last_idx - 6'd1));
	assign sts.last_idx = last_idx;
	assign sts.scan_i = scan_i;
endmodule

// ----- verif/testbench.sv -----
// Testbench for ir_distance_linearize_filter_core: calibration loads, samples and filter
// settings, checked beat by beat against an in-bench distance predictor.
// Depends on irdlf_pkg and the RTL of the core.
`timescale 1ns / 100ps
module testbench;
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               op;
	logic               channel;
	logic [5:0]         point_index;
	logic [7:0]         point_distance;
	logic [9:0]         point_code;
	logic [9:0]         sample_code;
	logic               out_valid;
	logic               out_ready;
	logic               result_channel;
	logic [15:0]        distance;
	logic signed [17:0] raw_distance;
	logic [1:0]         filter_mode;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	ir_distance_linearize_filter_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .channel(channel), .point_index(point_index),
		.point_distance(point_distance), .point_code(point_code),
		.sample_code(sample_code),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_channel(result_channel), .distance(distance),
		.raw_distance(raw_distance), .filter_mode(filter_mode),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// One expected result beat.
	typedef struct packed {
		logic               chan;
		logic [15:0]        dist_val;
		logic signed [17:0] raw;
		logic [1:0]         mode;
	} dist_result_t;

	dist_result_t expected_distances[$];

	// Predictor copy of the registers and block state.
	logic [15:0] snap_thr, med_thr, min_d, max_d;
	logic [8:0]  med_gain, slow_gain;
	logic [6:0]  pts_cfg [2];
	logic [7:0]  tbl_dist [2][64];
	logic [9:0]  tbl_code [2][64];
	bit          tbl_written [2][64];
	logic signed [17:0] filt_val [2];
	bit          first_wait [2];

	int  errors;
	int  samples_sent, loads_sent, results_seen;
	bit  out_idle_en, in_idle_en;
	bit  hold_receiver;
	int  mode_seen [4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout with %0d results still expected", expected_distances.size());
		$display("ir_distance_linearize_filter_core: mismatch");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
			results_seen);
	endtask

	function automatic int points_in_use(input int ch);
		int n;
		n = pts_cfg[ch];
		if (n < 2) n = 2;
		if (n > 64) n = 64;
		return n;
	endfunction

	// Segment choice and interpolation, saturated to 18 bits signed.
	function automatic logic signed [17:0] linearize(input int ch, input int c);
		int n, i;
		longint a0, a1, d0, d1, num, q, r, x, y;
		n = points_in_use(ch);
		if (c >= tbl_code[ch][0]) i = 0;
		else if (c <= tbl_code[ch][n-1]) i = n - 2;
		else begin
			for (i = 0; i < n - 1; i++) begin
				x = tbl_code[ch][i];
				y = tbl_code[ch][i+1];
				if (x >= y) begin
					if (c <= x && c >= y) break;
				end else if (c >= x && c <= y) break;
			end
			if (i >= n - 1) i = n - 2;
		end
		a0 = tbl_code[ch][i];
		a1 = tbl_code[ch][i+1];
		d0 = tbl_dist[ch][i];
		d1 = tbl_dist[ch][i+1];
		if (a0 == a1) return 18'(d0 * 256);
		num = (c - a0) * (d1 - d0) * 256;
		q = num / (a1 - a0);
		r = d0 * 256 + q;
		if (r > 131071) r = 131071;
		if (r < -131072) r = -131072;
		return 18'(r);
	endfunction

	function automatic logic signed [17:0] ema_blend(input longint f, input longint raw,
			input int g);
		longint s;
		if (g > 256) g = 256;
		s = f * (256 - g) + raw * g;
		if (s >= 0) return 18'(s / 256);
		return 18'(-((-s + 255) / 256));
	endfunction

	// Advances the predictor for one accepted item and queues any result.
	task automatic predict_item(input bit o, input bit ch, input int idx, input int pd,
			input int pc, input int sc);
		dist_result_t r;
		longint f, e;
		if (!o) begin
			tbl_dist[ch][idx] = 8'(pd);
			tbl_code[ch][idx] = 10'(pc);
			tbl_written[ch][idx] = 1;
			return;
		end
		r.raw = linearize(ch, sc);
		f = filt_val[ch];
		if (first_wait[ch]) begin
			f = r.raw;
			first_wait[ch] = 0;
			r.mode = irdlf_pkg::MODE_FIRST;
		end else begin
			e = r.raw - f;
			if (e < 0) e = -e;
			if (e > snap_thr) begin
				f = r.raw;
				r.mode = irdlf_pkg::MODE_SNAP;
			end else if (e > med_thr) begin
				f = ema_blend(f, r.raw, med_gain);
				r.mode = irdlf_pkg::MODE_MEDIUM;
			end else begin
				f = ema_blend(f, r.raw, slow_gain);
				r.mode = irdlf_pkg::MODE_SLOW;
			end
		end
		filt_val[ch] = 18'(f);
		if (f <= longint'(min_d)) r.dist_val = min_d;
		else if (f >= longint'(max_d)) r.dist_val = max_d;
		else r.dist_val = 16'(f);
		r.chan = ch;
		mode_seen[r.mode]++;
		expected_distances.push_back(r);
	endtask

	// Sends one beat and waits for its acceptance, with random idle cycles before it.
	task automatic send_item(input bit o, input bit ch, input int idx, input int pd,
			input int pc, input int sc);
		while (in_idle_en && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		op             <= o;
		channel        <= ch;
		point_index    <= 6'(idx);
		point_distance <= 8'(pd);
		point_code     <= 10'(pc);
		sample_code    <= 10'(sc);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(o, ch, idx, pd, pc, sc);
		if (o) samples_sent++;
		else loads_sent++;
		// Valid stays high; the next beat or a drain decides when it drops.
	endtask

	task automatic send_sample(input bit ch, input int sc);
		send_item(1'b1, ch, $urandom_range(63), $urandom_range(255), $urandom_range(1023), sc);
	endtask

	task automatic send_point(input bit ch, input int idx, input int pd, input int pc);
		send_item(1'b0, ch, idx, pd, pc, $urandom_range(1023));
	endtask

	// Waits for all results, then for the block's worst sample latency.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_distances.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 16'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			irdlf_pkg::REG_SNAP:   snap_thr = 16'(value);
			irdlf_pkg::REG_MEDT:   med_thr = 16'(value);
			irdlf_pkg::REG_MEDG:   med_gain = 9'(value);
			irdlf_pkg::REG_SLOWG:  slow_gain = 9'(value);
			irdlf_pkg::REG_MIND:   min_d = 16'(value);
			irdlf_pkg::REG_MAXD:   max_d = 16'(value);
			irdlf_pkg::REG_LEFTN:  pts_cfg[0] = 7'(value);
			irdlf_pkg::REG_FRONTN: pts_cfg[1] = 7'(value);
			default: ;
		endcase
	endtask

	// Fills every point of both tables so no unwritten entry can be read.
	task automatic fill_tables(input bit descending);
		int k, ch, code;
		for (ch = 0; ch < 2; ch++) begin
			for (k = 0; k < 64; k++) begin
				if ($urandom_range(9) == 0) code = $urandom_range(1023);
				else if (descending) code = 1000 - k * 15 - $urandom_range(5);
				else code = 20 + k * 15 + $urandom_range(5);
				if (code < 0) code = 0;
				send_point(ch, k, descending ? 7 + k * 3 : $urandom_range(255), code);
			end
		end
	endtask

	// Result checker: ready is random, high or held; compares each accepted beat.
	initial begin
		dist_result_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_distances.size() == 0) begin
					report_mismatch("unexpected result beat", 1, 0);
				end else begin
					want = expected_distances.pop_front();
					if (result_channel !== want.chan)
						report_mismatch("result_channel", result_channel, want.chan);
					if (distance !== want.dist_val)
						report_mismatch("distance", distance, want.dist_val);
					if (raw_distance !== want.raw)
						report_mismatch("raw_distance", raw_distance, want.raw);
					if (filter_mode !== want.mode)
						report_mismatch("filter_mode", filter_mode, want.mode);
				end
			end
			if (hold_receiver) out_ready <= 1'b0;
			else out_ready <= !(out_idle_en && $urandom_range(99) < 28);
		end
	end

	// Holds the receiver off for a long stretch, counted here.
	task automatic long_receiver_stall(input int cycles);
		hold_receiver = 1;
		repeat (cycles) @(posedge clk);
		hold_receiver = 0;
	endtask

	task automatic test_directed();
		fill_tables(1'b1);
		// First sample of each channel, then extremes of the code range.
		send_sample(0, 500);
		send_sample(1, 500);
		send_sample(0, 1023);
		send_sample(0, 0);
		send_sample(1, 1023);
		send_sample(1, 0);
		// Equal codes in a segment return d0.
		send_point(0, 0, 255, 800);
		send_point(0, 1, 0, 800);
		send_sample(0, 900);
		send_sample(0, 1023);
		// Rising codes at the start: extrapolation may go negative.
		send_point(1, 0, 255, 10);
		send_point(1, 1, 0, 11);
		send_sample(1, 1023);
		send_sample(1, 1022);
		drain_results();
	endtask

	task automatic test_config_extremes();
		// Out-of-range point counts saturate, gains 0 and 511, minimum above maximum.
		write_reg(irdlf_pkg::REG_LEFTN, 0);
		write_reg(irdlf_pkg::REG_FRONTN, 127);
		write_reg(irdlf_pkg::REG_MEDG, 511);
		write_reg(irdlf_pkg::REG_SLOWG, 0);
		write_reg(irdlf_pkg::REG_MIND, 65535);
		write_reg(irdlf_pkg::REG_MAXD, 0);
		write_reg(irdlf_pkg::REG_SNAP, 0);
		write_reg(irdlf_pkg::REG_MEDT, 65535);
		fill_tables(1'b0);
		repeat (20) send_sample($urandom_range(1), $urandom_range(1023));
		drain_results();
		write_reg(irdlf_pkg::REG_SNAP, 65535);
		write_reg(irdlf_pkg::REG_MEDT, 0);
		repeat (20) send_sample($urandom_range(1), $urandom_range(1023));
		drain_results();
	endtask

	task automatic test_random(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0)
				send_point($urandom_range(1), $urandom_range(63), $urandom_range(255),
					$urandom_range(1023));
			else send_sample($urandom_range(1), $urandom_range(1023));
		end
	endtask

	task automatic random_config();
		write_reg(irdlf_pkg::REG_SNAP, $urandom_range(6000));
		write_reg(irdlf_pkg::REG_MEDT, $urandom_range(2500));
		write_reg(irdlf_pkg::REG_MEDG, $urandom_range(300));
		write_reg(irdlf_pkg::REG_SLOWG, $urandom_range(300));
		write_reg(irdlf_pkg::REG_MIND, $urandom_range(4000));
		write_reg(irdlf_pkg::REG_MAXD, $urandom_range(70000) % 65536);
		write_reg(irdlf_pkg::REG_LEFTN, $urandom_range(2, 64));
		write_reg(irdlf_pkg::REG_FRONTN, $urandom_range(2, 64));
	endtask

	task automatic test_backpressure();
		fork
			long_receiver_stall(2000);
			test_random(10);
		join
		drain_results();
	endtask

	initial begin
		int ph;
		errors = 0;
		arst_n = 1'b0;
		in_valid = 1'b0; op = 1'b0; channel = 1'b0; point_index = '0;
		point_distance = '0; point_code = '0; sample_code = '0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		snap_thr = 3840; med_thr = 1280; med_gain = 128; slow_gain = 38;
		min_d = 1792; max_d = 16640; pts_cfg[0] = 36; pts_cfg[1] = 36;
		filt_val[0] = 0; filt_val[1] = 0; first_wait[0] = 1; first_wait[1] = 1;
		hold_receiver = 0;
		in_idle_en = 1; out_idle_en = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		write_reg(irdlf_pkg::REG_MIND, 0);
		write_reg(irdlf_pkg::REG_MAXD, 65535);
		test_backpressure();
		for (ph = 0; ph < 5; ph++) begin
			random_config();
			if (ph == 2) begin
				in_idle_en = 0;
				out_idle_en = 0;
			end else begin
				in_idle_en = 1;
				out_idle_en = 1;
			end
			test_random(60);
			drain_results();
		end
		drain_results();
		$display("covered %0d point loads and %0d samples, %0d results checked",
			loads_sent, samples_sent, results_seen);
		$display("filter modes first/snap/medium/slow: %0d/%0d/%0d/%0d",
			mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
		if (errors == 0 && expected_distances.size() == 0)
			$display("ir_distance_linearize_filter_core: match");
		else
			$display("ir_distance_linearize_filter_core: mismatch");
		$finish;
	end
endmodule
